// File: src/omni_wheel_kinematics_pwm_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the omni wheel drive block
// Immediate-implication and next-cycle checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_KINEMATICS_PWM_TOP_DEFINES_SVH
`define OMNI_WHEEL_KINEMATICS_PWM_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define OWK_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("omni wheel pipeline check failed");

// Check that cons holds in the cycle after ante
`define OWK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("omni wheel pipeline check failed");

`endif

// File: src/owk_pkg.sv
// ----------------------------------------------------------------------------
// owk_pkg
// Shared constants and types of the omni wheel kinematics and PWM block.
// ----------------------------------------------------------------------------
package owk_pkg;

   // Default fraction bits of the sine/cosine values
   localparam int FRACTION_BITS_DEFAULT = 15;

   // Pipeline depth, input register to output register
   localparam int NUM_STAGES = 8;

   // Duty scaling: duty = floor(level / 100), level = floor(|v| * 255 / 2^(2F))
   localparam int          LEVEL_WIDTH = 15;
   localparam int          DUTY_SHIFT  = 22;
   localparam logic [15:0] DUTY_RECIP  = 16'd41944;
   localparam logic [7:0]  DUTY_MAX    = 8'd255;
   localparam int          FULL_PERCENT = 100;

   // Stage enables of one wheel's drive pipeline
   typedef struct packed {
      logic mag;
      logic scale;
      logic duty;
   } wheel_en_type;

endpackage

// File: src/owk_wheel_drive.sv
// ----------------------------------------------------------------------------
// owk_wheel_drive
// Turns one signed wheel speed into a direction bit and a saturated PWM duty
// over three register stages: magnitude, level scaling, divide by 100.
// ----------------------------------------------------------------------------
module owk_wheel_drive #(
   parameter int FRACTION_BITS = owk_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  owk_pkg::wheel_en_type             en,
   input  logic signed [2*FRACTION_BITS+9:0] speed,
   output logic                              dir,
   output logic [7:0]                        duty
);
   import owk_pkg::*;

   localparam int VW = 2 * FRACTION_BITS + 10;
   localparam int MW = VW - 1;
   localparam logic [MW-1:0] FULL = MW'(FULL_PERCENT) << (2 * FRACTION_BITS);

   logic [MW-1:0]          mag_in, mag_ff;
   logic                   dir_mag_ff;
   logic [VW+6:0]          scaled;
   logic [LEVEL_WIDTH-1:0] level_in, level_ff;
   logic                   sat_in, sat_ff, dir_scale_ff;
   logic [LEVEL_WIDTH+15:0] quot;
   logic [7:0]             duty_in, duty_ff;
   logic                   dir_ff;

   // Take the magnitude; direction is the sign
   always_comb begin
      logic signed [VW-1:0] neg;
      neg    = -speed;
      mag_in = speed[VW-1] ? neg[MW-1:0] : speed[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.mag) begin
         mag_ff     <= mag_in;
         dir_mag_ff <= speed[VW-1];
      end
   end

   // Scale by 255 and drop the fraction; flag saturation
   assign scaled   = {mag_ff, 8'b0} - (VW+7)'(mag_ff);
   assign level_in = scaled[2*FRACTION_BITS +: LEVEL_WIDTH];
   assign sat_in   = (mag_ff >= FULL);

   always_ff @(posedge clock) begin
      if (en.scale) begin
         level_ff     <= level_in;
         sat_ff       <= sat_in;
         dir_scale_ff <= dir_mag_ff;
      end
   end

   // Divide the level by 100 through the reciprocal
   assign quot    = level_ff * DUTY_RECIP;
   assign duty_in = sat_ff ? DUTY_MAX : quot[DUTY_SHIFT +: 8];

   always_ff @(posedge clock) begin
      if (en.duty) begin
         duty_ff <= duty_in;
         dir_ff  <= dir_scale_ff;
      end
   end

   assign dir  = dir_ff;
   assign duty = duty_ff;

endmodule

// File: src/omni_wheel_kinematics_pwm_top.sv
// Each accepted command beat runs through stages 1 to 8 and leaves as its result beat.
// Throughput: one command per cycle, sustained while the result side takes
// one beat per cycle; the eight-stage pipeline with per-stage valid bits
// fills bubbles under a stall.
// Reset: clears the valid bits only; no state, no clearing pass.
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_pwm_top
// Three-wheel omni drive inverse kinematics: speed and heading split into
// Vx/Vy by a quarter-wave sine table, three wheel speeds, PWM duty per wheel.
// ----------------------------------------------------------------------------
`include "omni_wheel_kinematics_pwm_top_defines.svh"

module omni_wheel_kinematics_pwm_top #(
   parameter int FRACTION_BITS = owk_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [6:0]        req_speed,
   input  logic [8:0]        req_heading_deg,
   input  logic signed [7:0] req_spin,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_dir_a,
   output logic [7:0]        rsp_duty_a,
   output logic              rsp_dir_b,
   output logic [7:0]        rsp_duty_b,
   output logic              rsp_dir_c,
   output logic [7:0]        rsp_duty_c
);
   import owk_pkg::*;

   localparam int SW = FRACTION_BITS + 2;       // signed sine value
   localparam int PW = FRACTION_BITS + 10;      // speed times sine
   localparam int VW = 2 * FRACTION_BITS + 10;  // wheel speed
   localparam int QUARTER_ENTRIES = 91;
   localparam logic [8:0] FULL_TURN = 9'd360;
   localparam logic [8:0] RIGHT     = 9'd90;
   localparam logic [8:0] HALF_TURN = 9'd180;
   localparam logic [8:0] THREE_Q   = 9'd270;
   localparam longint unsigned ONE30 = 64'd1 << 30;

   typedef struct packed {
      logic [6:0] idx;
      logic       neg;
   } fold_type;

   // Quarter sine in Q(FRACTION_BITS), Taylor series in Q30 (elaboration only)
   function automatic longint unsigned quarter_sine_q(input int unsigned d);
      longint unsigned x, x2, t, s;
      x  = ((64'(d) * 64'd314159) << 30) / 64'd18000000;
      x2 = (x * x) >> 30;
      t  = ONE30;
      t  = ONE30 - ((x2 * t) >> 30) / 64'd156;
      t  = ONE30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
      return s;
   endfunction

   // Fold an angle in 0..359 into the first quarter with a sign
   function automatic fold_type fold_angle(input logic [8:0] a);
      fold_type   r;
      logic [8:0] tmp;
      if (a <= RIGHT) begin
         tmp = a;
         r.neg = 1'b0;
      end else if (a <= HALF_TURN) begin
         tmp = HALF_TURN - a;
         r.neg = 1'b0;
      end else if (a <= THREE_Q) begin
         tmp = a - HALF_TURN;
         r.neg = 1'b1;
      end else begin
         tmp = FULL_TURN - a;
         r.neg = 1'b1;
      end
      r.idx = tmp[6:0];
      return r;
   endfunction

   localparam logic signed [SW-1:0] S60 = SW'(quarter_sine_q(60));

   logic [SW-2:0] sine_rom [QUARTER_ENTRIES];

   for (genvar g = 0; g < QUARTER_ENTRIES; g++) begin : g_sine
      assign sine_rom[g] = (SW-1)'(quarter_sine_q(g));
   end

   // ---------------------------------------------------------------------
   // Stage handshake: a stage advances when empty or when the next advances
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, adv;

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------------
   // Stage 1: wrap heading, fold sine and cosine angles
   // ---------------------------------------------------------------------
   logic [8:0]        hd, ca;
   logic [9:0]        ca_wide;
   fold_type          sin_fold_in, cos_fold_in, sin_fold_ff, cos_fold_ff;
   logic [6:0]        speed_s1_ff;
   logic signed [7:0] spin_s1_ff;

   always_comb begin
      hd      = (req_heading_deg >= FULL_TURN) ? req_heading_deg - FULL_TURN
                                               : req_heading_deg;
      ca_wide = {1'b0, hd} + {1'b0, RIGHT};
      ca      = (ca_wide >= {1'b0, FULL_TURN}) ? 9'(ca_wide - {1'b0, FULL_TURN})
                                               : ca_wide[8:0];
      sin_fold_in = fold_angle(hd);
      cos_fold_in = fold_angle(ca);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sin_fold_ff <= sin_fold_in;
         cos_fold_ff <= cos_fold_in;
         speed_s1_ff <= req_speed;
         spin_s1_ff  <= req_spin;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: table lookup, apply quarter sign
   // ---------------------------------------------------------------------
   logic signed [SW-1:0] sin_mag, cos_mag, sin_s2_ff, cos_s2_ff;
   logic [6:0]           speed_s2_ff;
   logic signed [7:0]    spin_s2_ff;

   assign sin_mag = $signed({1'b0, sine_rom[sin_fold_ff.idx]});
   assign cos_mag = $signed({1'b0, sine_rom[cos_fold_ff.idx]});

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sin_s2_ff   <= sin_fold_ff.neg ? -sin_mag : sin_mag;
         cos_s2_ff   <= cos_fold_ff.neg ? -cos_mag : cos_mag;
         speed_s2_ff <= speed_s1_ff;
         spin_s2_ff  <= spin_s1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: Vx = speed * cos, Vy = speed * sin
   // ---------------------------------------------------------------------
   logic signed [7:0]    speed_signed;
   logic signed [PW-1:0] vx_s3_ff, vy_s3_ff;
   logic signed [7:0]    spin_s3_ff;

   assign speed_signed = $signed({1'b0, speed_s2_ff});

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         vx_s3_ff   <= speed_signed * cos_s2_ff;
         vy_s3_ff   <= speed_signed * sin_s2_ff;
         spin_s3_ff <= spin_s2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: Vy * sin60
   // ---------------------------------------------------------------------
   logic signed [PW+SW-1:0] vy_prod;
   logic signed [VW-1:0]    p_s4_ff;
   logic signed [PW-1:0]    vx_s4_ff;
   logic signed [7:0]       spin_s4_ff;

   assign vy_prod = vy_s3_ff * S60;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         p_s4_ff    <= $signed(vy_prod[VW-1:0]);
         vx_s4_ff   <= vx_s3_ff;
         spin_s4_ff <= spin_s3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: the three wheel speeds in Q(2F)
   // ---------------------------------------------------------------------
   logic signed [VW-1:0] vx_ext, w_ext, vx_half, w_full;
   logic signed [VW-1:0] va_s5_ff, vb_s5_ff, vc_s5_ff;

   assign vx_ext  = VW'(vx_s4_ff);
   assign w_ext   = VW'(spin_s4_ff);
   assign vx_half = vx_ext <<< (FRACTION_BITS - 1);
   assign w_full  = w_ext <<< (2 * FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         va_s5_ff <= vx_half + p_s4_ff + w_full;
         vb_s5_ff <= vx_half - p_s4_ff + w_full;
         vc_s5_ff <= -((vx_ext + (w_ext <<< FRACTION_BITS)) <<< FRACTION_BITS);
      end
   end

   // ---------------------------------------------------------------------
   // Stages 6 to 8: direction and duty per wheel
   // ---------------------------------------------------------------------
   wheel_en_type wheel_en;

   assign wheel_en.mag   = adv[5];
   assign wheel_en.scale = adv[6];
   assign wheel_en.duty  = adv[7];

   owk_wheel_drive #(.FRACTION_BITS(FRACTION_BITS)) u_wheel_a (
      .clock (clock),
      .en    (wheel_en),
      .speed (va_s5_ff),
      .dir   (rsp_dir_a),
      .duty  (rsp_duty_a)
   );

   owk_wheel_drive #(.FRACTION_BITS(FRACTION_BITS)) u_wheel_b (
      .clock (clock),
      .en    (wheel_en),
      .speed (vb_s5_ff),
      .dir   (rsp_dir_b),
      .duty  (rsp_duty_b)
   );

   owk_wheel_drive #(.FRACTION_BITS(FRACTION_BITS)) u_wheel_c (
      .clock (clock),
      .en    (wheel_en),
      .speed (vc_s5_ff),
      .dir   (rsp_dir_c),
      .duty  (rsp_duty_c)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `OWK_ASSERT_NOW(a_ready_when_first_empty, !valid_ff[0], req_ready)
   `OWK_ASSERT_NOW(a_hold_when_full_stalled, (&valid_ff) && !rsp_ready, !req_ready)
   `OWK_ASSERT_NEXT(a_beat_enters_first, req_valid && req_ready, valid_ff[0])

endmodule

// File: tb/omni_wheel_kinematics_pwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_pwm_checker
// Watches the command and result channels of the omni wheel drive block.
// Every accepted command beat is turned into the expected wheel directions
// and duties. Each result beat is checked against the oldest one waiting.
// ----------------------------------------------------------------------------
module omni_wheel_kinematics_pwm_checker #(
   parameter int FRAC_BITS = owk_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [6:0]        req_speed,
   input  logic [8:0]        req_heading_deg,
   input  logic signed [7:0] req_spin,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_dir_a,
   input  logic [7:0]        rsp_duty_a,
   input  logic              rsp_dir_b,
   input  logic [7:0]        rsp_duty_b,
   input  logic              rsp_dir_c,
   input  logic [7:0]        rsp_duty_c,
   output int                fail_count,
   output int                pending
);

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam logic [7:0]      DUTY_FULL = 8'd255;

   typedef struct packed {
      logic       dir_a;
      logic [7:0] duty_a;
      logic       dir_b;
      logic [7:0] duty_b;
      logic       dir_c;
      logic [7:0] duty_c;
   } wheel_drive_type;

   wheel_drive_type drive_q [$];
   wheel_drive_type want;
   wheel_drive_type got;

   // Sine of 0..90 degrees: Taylor series in Horner form, Q30, then rounded
   function automatic longint sin_first_quadrant(input longint unsigned deg);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned acc;
      ang  = ((deg * 64'd314159) << 30) / 64'd18000000;
      ang2 = (ang * ang) >> 30;
      acc  = ONE_Q30;
      // divisors run (2k)(2k+1) from the x^13 term down to x^3
      for (int k = 6; k > 0; k--) begin
         acc = ONE_Q30 - ((ang2 * acc) >> 30) / (2 * k * (2 * k + 1));
      end
      acc = (ang * acc) >> 30;
      acc = (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return longint'(acc);
   endfunction

   // Fold a whole-degree angle into the first quadrant
   function automatic longint sin_of_degrees(input int unsigned d);
      if (d <= 90)
         return sin_first_quadrant(d);
      else if (d <= 180)
         return sin_first_quadrant(180 - d);
      else if (d <= 270)
         return -sin_first_quadrant(d - 180);
      else
         return -sin_first_quadrant(360 - d);
   endfunction

   // Direction and duty of one wheel speed held in Q(2F) percent
   function automatic void wheel_pwm(input longint v, output logic dir,
                                     output logic [7:0] duty);
      longint unsigned full;
      longint unsigned mag;
      longint unsigned scaled;
      full = 64'd100 << (2 * FRAC_BITS);
      dir  = (v < 0);
      if (v < 0)
         mag = longint'(-v);
      else
         mag = longint'(v);
      scaled = (mag * 64'd255) / full;
      if (mag >= full)
         duty = DUTY_FULL;
      else
         duty = scaled[7:0];
   endfunction

   // Inverse kinematics of one command
   function automatic wheel_drive_type predict_drive(input logic [6:0] speed,
                                                     input logic [8:0] heading,
                                                     input logic signed [7:0] spin);
      longint          spd;
      longint          w;
      longint          cosv;
      longint          sinv;
      longint          sin60;
      longint          vx;
      longint          vy;
      longint          half;
      longint          unit;
      longint          unit2;
      int unsigned     hd;
      wheel_drive_type res;
      spd   = speed;
      w     = spin;
      hd    = heading % 360;
      cosv  = sin_of_degrees((hd + 90) % 360);
      sinv  = sin_of_degrees(hd);
      sin60 = sin_of_degrees(60);
      vx    = spd * cosv;
      vy    = spd * sinv;
      half  = longint'(1) << (FRAC_BITS - 1);
      unit  = longint'(1) << FRAC_BITS;
      unit2 = longint'(1) << (2 * FRAC_BITS);
      wheel_pwm(vx * half + vy * sin60 + w * unit2, res.dir_a, res.duty_a);
      wheel_pwm(vx * half - vy * sin60 + w * unit2, res.dir_b, res.duty_b);
      // wheel C kept as the drive formula gives it, spin inside the negation
      wheel_pwm(-(vx + w * unit) * unit, res.dir_c, res.duty_c);
      return res;
   endfunction

   // Predict on each command beat, compare on each result beat
   always @(posedge clock) begin
      if (reset) begin
         drive_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            drive_q.push_back(predict_drive(req_speed, req_heading_deg, req_spin));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_dir_a, rsp_duty_a, rsp_dir_b, rsp_duty_b, rsp_dir_c, rsp_duty_c};
            if (drive_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result beat with no command waiting: A %0d/%0d B %0d/%0d C %0d/%0d",
                           $time, got.dir_a, got.duty_a, got.dir_b, got.duty_b,
                           got.dir_c, got.duty_c);
               fail_count++;
            end else begin
               want = drive_q.pop_front();
               if (got.dir_a !== want.dir_a || got.duty_a !== want.duty_a ||
                   got.dir_b !== want.dir_b || got.duty_b !== want.duty_b ||
                   got.dir_c !== want.dir_c || got.duty_c !== want.duty_c) begin
                  if (fail_count < 10)
                     $display("%0t: wheel mismatch, expected A %0d/%0d B %0d/%0d C %0d/%0d, got A %0d/%0d B %0d/%0d C %0d/%0d",
                              $time, want.dir_a, want.duty_a, want.dir_b, want.duty_b,
                              want.dir_c, want.duty_c, got.dir_a, got.duty_a,
                              got.dir_b, got.duty_b, got.dir_c, got.duty_c);
                  fail_count++;
               end
            end
         end
      end
      pending = drive_q.size();
   end

endmodule

// File: tb/omni_wheel_kinematics_pwm_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_pwm_top_test
// Drives motion commands into the omni wheel drive block: a directed set of
// corner commands, then random bursts with gaps, one long result stall and
// drain pauses. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module omni_wheel_kinematics_pwm_top_test;

   localparam int FRAC_BITS    = owk_pkg::FRACTION_BITS_DEFAULT;
   localparam int RANDOM_CMDS  = 1925;
   localparam int LONG_HOLD    = 120;
   localparam int HOLD_BURST   = 40;
   localparam int RUN_LIMIT_NS = 2_000_000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [6:0]        req_speed;
   logic [8:0]        req_heading_deg;
   logic signed [7:0] req_spin;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_dir_a;
   logic [7:0]        rsp_duty_a;
   logic              rsp_dir_b;
   logic [7:0]        rsp_duty_b;
   logic              rsp_dir_c;
   logic [7:0]        rsp_duty_c;
   logic              long_hold_req;
   int                fail_count;
   int                pending;

   // 4 ns clock period
   initial clock = 1'b0;
   always #2 clock = ~clock;

   omni_wheel_kinematics_pwm_top #(
      .FRACTION_BITS(FRAC_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_speed       (req_speed),
      .req_heading_deg (req_heading_deg),
      .req_spin        (req_spin),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dir_a       (rsp_dir_a),
      .rsp_duty_a      (rsp_duty_a),
      .rsp_dir_b       (rsp_dir_b),
      .rsp_duty_b      (rsp_duty_b),
      .rsp_dir_c       (rsp_dir_c),
      .rsp_duty_c      (rsp_duty_c)
   );

   omni_wheel_kinematics_pwm_checker #(
      .FRAC_BITS(FRAC_BITS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_speed       (req_speed),
      .req_heading_deg (req_heading_deg),
      .req_spin        (req_spin),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dir_a       (rsp_dir_a),
      .rsp_duty_a      (rsp_duty_a),
      .rsp_dir_b       (rsp_dir_b),
      .rsp_duty_b      (rsp_duty_b),
      .rsp_dir_c       (rsp_dir_c),
      .rsp_duty_c      (rsp_duty_c),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // Offer one command beat and hold it until taken; returns on a falling edge
   task automatic send_cmd(input logic [6:0] sp, input logic [8:0] hd,
                           input logic signed [7:0] sn);
      req_valid       <= 1'b1;
      req_speed       <= sp;
      req_heading_deg <= hd;
      req_spin        <= sn;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid for a gap of length n; a zero n leaves valid as it is
   task automatic idle(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Hold off until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Mostly legal commands, some full-range, some near zero speed and spin
   task automatic send_random_cmd();
      logic [6:0]        sp;
      logic [8:0]        hd;
      logic signed [7:0] sn;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         sp = 7'($urandom_range(0, 100));
         hd = 9'($urandom_range(0, 359));
         sn = 8'($urandom_range(0, 200) - 100);
      end else if (pick < 85) begin
         sp = 7'($urandom);
         hd = 9'($urandom);
         sn = 8'($urandom);
      end else begin
         sp = 7'($urandom_range(0, 3));
         hd = 9'($urandom_range(0, 359));
         sn = 8'($urandom_range(0, 6) - 3);
      end
      send_cmd(sp, hd, sn);
   endtask

   // Result side: stall patterns that change now and then, one long hold
   initial begin : rsp_side
      int mode;
      int left;
      int phase;
      bit hold_seen;
      rsp_ready = 1'b0;
      mode      = 0;
      left      = 0;
      phase     = 0;
      hold_seen = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(10, 150);
            end
            left--;
            phase++;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (phase % 4 != 3);
            endcase
         end
      end
   end

   // Give up after a generous fixed time
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int burst;
      int gap;
      int next_pause;
      bit hold_done;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_speed       = '0;
      req_heading_deg = '0;
      req_spin        = '0;
      long_hold_req   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: standstill, cardinal headings, field extremes, wraps
      send_cmd(7'd0,   9'd0,   8'sd0);
      send_cmd(7'd100, 9'd0,   8'sd0);
      send_cmd(7'd100, 9'd90,  8'sd0);
      send_cmd(7'd100, 9'd180, 8'sd0);
      send_cmd(7'd100, 9'd270, 8'sd0);
      send_cmd(7'd100, 9'd359, 8'sd0);
      send_cmd(7'd0,   9'd0,   8'sd100);
      send_cmd(7'd0,   9'd0,   -8'sd100);
      send_cmd(7'd0,   9'd0,   8'sd127);
      send_cmd(7'd0,   9'd0,   -8'sd128);
      send_cmd(7'd127, 9'd45,  8'sd127);
      send_cmd(7'd127, 9'd511, -8'sd128);
      send_cmd(7'd100, 9'd360, 8'sd0);
      send_cmd(7'd50,  9'd510, 8'sd20);
      // wheel B cancels at 30 degrees
      send_cmd(7'd100, 9'd30,  8'sd0);
      // wheel C cancels: Vx of -1 against a spin of 1
      send_cmd(7'd1,   9'd180, 8'sd1);
      // small speeds, reverse on some wheels; some duties truncate to zero
      send_cmd(7'd1,   9'd90,  -8'sd1);
      send_cmd(7'd1,   9'd240, 8'sd0);
      send_cmd(7'd1,   9'd200, 8'sd0);
      send_cmd(7'd100, 9'd0,   -8'sd100);
      send_cmd(7'd100, 9'd120, 8'sd100);
      send_cmd(7'd64,  9'd256, 8'sd64);
      wait_drained();

      // Random bursts with gaps, one long result hold and drain pauses
      sent       = 0;
      next_pause = 500;
      hold_done  = 1'b0;
      while (sent < RANDOM_CMDS) begin
         if (!hold_done && sent >= 700) begin
            long_hold_req = 1'b1;
            repeat (HOLD_BURST) send_random_cmd();
            sent += HOLD_BURST;
            hold_done = 1'b1;
         end
         if (sent >= next_pause) begin
            wait_drained();
            next_pause += 500;
         end
         burst = $urandom_range(1, 48);
         repeat (burst) send_random_cmd();
         sent += burst;
         if ($urandom_range(0, 3) == 0)
            gap = 0;
         else
            gap = $urandom_range(1, 12);
         idle(gap);
      end

      // Drain, let the pipeline run empty, then give the verdict
      wait_drained();
      repeat (owk_pkg::NUM_STAGES * 4) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
